@@ rtl/trg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trg_pkg
// Shared widths, multiplier operand codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package trg_pkg;

    localparam int TRG_VERTEX_COUNT = 4096;

    localparam int IDX_W     = 12;
    localparam int POS_W     = 32;
    localparam int TEX_W     = 24;
    localparam int TAN_W     = 16;
    localparam int VTX_W     = 3 * POS_W + 2 * TEX_W;
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 64;

    // multiplier operand selects; pairs form a - b
    localparam logic [3:0] MS_DET_A = 4'd0;
    localparam logic [3:0] MS_DET_B = 4'd1;
    localparam logic [3:0] MS_WX_A  = 4'd2;
    localparam logic [3:0] MS_WX_B  = 4'd3;
    localparam logic [3:0] MS_WY_A  = 4'd4;
    localparam logic [3:0] MS_WY_B  = 4'd5;
    localparam logic [3:0] MS_WZ_A  = 4'd6;
    localparam logic [3:0] MS_WZ_B  = 4'd7;
    localparam logic [3:0] MS_SQ_X  = 4'd8;
    localparam logic [3:0] MS_SQ_Y  = 4'd9;
    localparam logic [3:0] MS_SQ_Z  = 4'd10;

    typedef struct packed {
        logic [1:0] rd_idx;
        logic       cap_en;
        logic [1:0] cap_idx;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       norm_en;
        logic       sqrt_init;
        logic       sqrt_step;
        logic [4:0] sqrt_k;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic [1:0] comp;
        logic [1:0] out_k;
    } trg_cmd_t;

    typedef struct packed {
        logic deg;
        logic norm_busy;
    } trg_sts_t;

endpackage
`default_nettype wire

@@ rtl/trg_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ rtl/trg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trg_ctrl
// Sequencer: vertex fetch, products, normalize, sqrt, divide, result issue.
// ----------------------------------------------------------------------------
module trg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               tri_start,
    input  wire logic               out_take,
    input  wire trg_pkg::trg_sts_t  sts,
    output trg_pkg::trg_cmd_t       cmd,
    output logic                    s_ready,
    output logic                    m_valid,
    output logic                    m_last
);
    import trg_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_MULT = 3'd2;
    localparam logic [2:0] ST_NORM = 3'd3;
    localparam logic [2:0] ST_SQ   = 3'd4;
    localparam logic [2:0] ST_SQRT = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        cmd        = '0;
        cmd.comp   = comp_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_last     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (tri_start) begin
                    state_next = ST_READ;
                    cnt_next   = '0;
                end
            end
            ST_READ: begin
                // last cycle only captures; the read address stays on corner c
                cmd.rd_idx = (cnt_reg == 6'd3) ? 2'd2 : cnt_reg[1:0];
                if (cnt_reg != 6'd0) begin
                    cmd.cap_en  = 1'b1;
                    cmd.cap_idx = cnt_reg[1:0] - 2'd1;
                end
                if (cnt_reg == 6'd3) begin
                    state_next = ST_MULT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_MULT: begin
                cmd.mul_en  = (cnt_reg < 6'd8);
                cmd.mul_sel = cnt_reg[3:0];
                if (cnt_reg == 6'd8) begin
                    state_next = ST_NORM;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_NORM: begin
                priority if (sts.deg) begin
                    state_next = ST_OUT;
                    cnt_next   = '0;
                end else if (sts.norm_busy) begin
                    cmd.norm_en = 1'b1;
                end else begin
                    state_next = ST_SQ;
                    cnt_next   = '0;
                end
            end
            ST_SQ: begin
                cmd.mul_en  = (cnt_reg < 6'd3);
                cmd.mul_sel = MS_SQ_X + cnt_reg[3:0];
                if (cnt_reg == 6'd3) begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_init = (cnt_reg == 6'd0);
                cmd.sqrt_step = (cnt_reg != 6'd0);
                cmd.sqrt_k    = 5'(6'd32 - cnt_reg);
                if (cnt_reg == 6'd32) begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    comp_next  = '0;
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_DIV: begin
                cmd.div_init  = (cnt_reg == 6'd0);
                cmd.div_step  = (cnt_reg != 6'd0) && (cnt_reg != 6'd18);
                cmd.div_store = (cnt_reg == 6'd18);
                if (cnt_reg == 6'd18) begin
                    cnt_next = '0;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_OUT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_OUT: begin
                cmd.out_k = cnt_reg[1:0];
                m_valid   = 1'b1;
                m_last    = (cnt_reg[1:0] == 2'd2);
                if (out_take) begin
                    if (cnt_reg[1:0] == 2'd2) begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end else begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/trg_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// trg_dp
// Datapath: vertex store, shared multiplier, normalizer, sqrt and divider.
// ----------------------------------------------------------------------------
module trg_dp #(
    parameter int VERTEX_COUNT = trg_pkg::TRG_VERTEX_COUNT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire trg_pkg::trg_cmd_t             cmd,
    input  wire logic                          load_en,
    input  wire logic                          tri_start,
    input  wire logic [trg_pkg::S_TDATA_W-1:0] in_data,
    output trg_pkg::trg_sts_t                  sts,
    output logic [trg_pkg::IDX_W-1:0]          target_vertex,
    output logic [trg_pkg::TAN_W-1:0]          tan_x,
    output logic [trg_pkg::TAN_W-1:0]          tan_y,
    output logic [trg_pkg::TAN_W-1:0]          tan_z,
    output logic                               degenerate
);
    import trg_pkg::*;

    localparam int AW = $clog2(VERTEX_COUNT);

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return (32'(idx) < VERTEX_COUNT);
    endfunction

    // input fields
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] crn_in [3];
    assign slot      = in_data[11:0];
    assign crn_in[0] = in_data[167:156];
    assign crn_in[1] = in_data[179:168];
    assign crn_in[2] = in_data[191:180];

    // vertex store: {tex_v, tex_u, pos_z, pos_y, pos_x}
    logic [AW-1:0]    raddr;
    logic [VTX_W-1:0] rdata;
    logic [IDX_W-1:0] corner_reg [3];

    assign raddr = AW'(corner_reg[cmd.rd_idx]);

    trg_ram #(
        .WIDTH (VTX_W),
        .DEPTH (VERTEX_COUNT)
    ) u_store (
        .aclk  (aclk),
        .we    (load_en && in_range(slot)),
        .waddr (AW'(slot)),
        .wdata (in_data[155:12]),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (tri_start) begin
            corner_reg <= crn_in;
        end
    end

    // captured corners
    logic signed [POS_W-1:0] pos_reg [3][3];
    logic signed [TEX_W-1:0] tex_reg [3][2];
    logic                    cap_ok;
    assign cap_ok = in_range(corner_reg[cmd.cap_idx]);

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            for (int i = 0; i < 3; i++) begin
                pos_reg[cmd.cap_idx][i] <= cap_ok ? rdata[i*POS_W +: POS_W] : '0;
            end
            for (int i = 0; i < 2; i++) begin
                tex_reg[cmd.cap_idx][i] <= cap_ok ? rdata[3*POS_W + i*TEX_W +: TEX_W] : '0;
            end
        end
    end

    // edge and uv deltas
    logic signed [POS_W:0] e1 [3];
    logic signed [POS_W:0] e2 [3];
    logic signed [TEX_W:0] du1, dv1, du2, dv2;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = (POS_W+1)'(pos_reg[1][i]) - (POS_W+1)'(pos_reg[0][i]);
            e2[i] = (POS_W+1)'(pos_reg[2][i]) - (POS_W+1)'(pos_reg[0][i]);
        end
        du1 = (TEX_W+1)'(tex_reg[1][0]) - (TEX_W+1)'(tex_reg[0][0]);
        dv1 = (TEX_W+1)'(tex_reg[1][1]) - (TEX_W+1)'(tex_reg[0][1]);
        du2 = (TEX_W+1)'(tex_reg[2][0]) - (TEX_W+1)'(tex_reg[0][0]);
        dv2 = (TEX_W+1)'(tex_reg[2][1]) - (TEX_W+1)'(tex_reg[0][1]);
    end

    // shared multiplier
    logic [59:0]        mag_reg [3];
    logic [2:0]         neg_reg;
    logic signed [33:0] mul_a;
    logic signed [30:0] mul_b;
    logic signed [63:0] mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_sel)
            MS_DET_A: begin mul_a = 34'(du1);   mul_b = 31'(dv2); end
            MS_DET_B: begin mul_a = 34'(dv1);   mul_b = 31'(du2); end
            MS_WX_A:  begin mul_a = 34'(e1[0]); mul_b = 31'(dv2); end
            MS_WX_B:  begin mul_a = 34'(e2[0]); mul_b = 31'(dv1); end
            MS_WY_A:  begin mul_a = 34'(e1[1]); mul_b = 31'(dv2); end
            MS_WY_B:  begin mul_a = 34'(e2[1]); mul_b = 31'(dv1); end
            MS_WZ_A:  begin mul_a = 34'(e1[2]); mul_b = 31'(dv2); end
            MS_WZ_B:  begin mul_a = 34'(e2[2]); mul_b = 31'(dv1); end
            MS_SQ_X:  begin mul_a = {4'b0, mag_reg[0][29:0]}; mul_b = {1'b0, mag_reg[0][29:0]}; end
            MS_SQ_Y:  begin mul_a = {4'b0, mag_reg[1][29:0]}; mul_b = {1'b0, mag_reg[1][29:0]}; end
            MS_SQ_Z:  begin mul_a = {4'b0, mag_reg[2][29:0]}; mul_b = {1'b0, mag_reg[2][29:0]}; end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = 64'(mul_a) * 64'(mul_b);
    end

    logic signed [63:0] prod_reg, hold_reg;
    logic [3:0]         prod_sel_reg;
    logic               prod_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg     <= mul_p;
            prod_sel_reg <= cmd.mul_sel;
        end
    end

    // product write-back
    logic signed [63:0] diff;
    logic [63:0]        diff_abs;
    logic               det_zero_reg, det_neg_reg;
    logic [63:0]        sum_reg;

    assign diff     = hold_reg - prod_reg;
    assign diff_abs = diff[63] ? 64'(-diff) : 64'(diff);

    // normalize: largest magnitude into [2^29, 2^30), one bit per cycle
    logic [59:0] mag_or;
    logic        sh_right, sh_left;
    assign mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign sh_right = |mag_or[59:30];
    assign sh_left  = ~|mag_or[59:29];

    always_ff @(posedge aclk) begin
        if (prod_vld_reg) begin
            unique case (prod_sel_reg)
                MS_DET_A, MS_WX_A, MS_WY_A, MS_WZ_A: hold_reg <= prod_reg;
                MS_DET_B: begin
                    det_zero_reg <= (diff == 64'sd0);
                    det_neg_reg  <= diff[63];
                end
                MS_WX_B: begin
                    mag_reg[0] <= diff_abs[59:0];
                    neg_reg[0] <= diff[63] ^ det_neg_reg;
                end
                MS_WY_B: begin
                    mag_reg[1] <= diff_abs[59:0];
                    neg_reg[1] <= diff[63] ^ det_neg_reg;
                end
                MS_WZ_B: begin
                    mag_reg[2] <= diff_abs[59:0];
                    neg_reg[2] <= diff[63] ^ det_neg_reg;
                end
                MS_SQ_X: sum_reg <= 64'(prod_reg);
                MS_SQ_Y, MS_SQ_Z: sum_reg <= sum_reg + 64'(prod_reg);
                default: hold_reg <= hold_reg;
            endcase
        end else if (cmd.norm_en) begin
            for (int i = 0; i < 3; i++) begin
                priority if (sh_right) begin
                    mag_reg[i] <= mag_reg[i] >> 1;
                end else if (sh_left) begin
                    mag_reg[i] <= mag_reg[i] << 1;
                end
            end
        end
    end

    assign sts.deg       = det_zero_reg || (mag_or == 60'd0);
    assign sts.norm_busy = sh_right || sh_left;

    // square root, one result bit per cycle
    logic [63:0] x_reg, r_reg, sq_bit, sq_try;
    assign sq_bit = 64'd1 << {cmd.sqrt_k, 1'b0};
    assign sq_try = r_reg + sq_bit;

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_init) begin
            x_reg <= sum_reg;
            r_reg <= '0;
        end else if (cmd.sqrt_step) begin
            if (x_reg >= sq_try) begin
                x_reg <= x_reg - sq_try;
                r_reg <= (r_reg >> 1) + sq_bit;
            end else begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    // restoring divider, 17 quotient bits per component
    logic [31:0] len;
    logic [45:0] num;
    logic [32:0] rem_reg, rem_try;
    logic [16:0] low_reg, q_reg, q_cap;
    assign len     = r_reg[31:0];
    assign num     = {1'b0, mag_reg[cmd.comp][29:0], 15'b0} + 46'(len[31:1]);
    assign rem_try = {rem_reg[31:0], low_reg[16]};

    logic [TAN_W-1:0] tan_reg [3];

    always_comb begin
        if (neg_reg[cmd.comp]) begin
            q_cap = (q_reg > 17'd32768) ? 17'd32768 : q_reg;
            q_cap = 17'(-q_cap);
        end else begin
            q_cap = (q_reg > 17'd32767) ? 17'd32767 : q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg <= 33'(num[45:17]);
            low_reg <= num[16:0];
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            low_reg <= low_reg << 1;
            if (rem_try >= {1'b0, len}) begin
                rem_reg <= rem_try - {1'b0, len};
                q_reg   <= {q_reg[15:0], 1'b1};
            end else begin
                rem_reg <= rem_try;
                q_reg   <= {q_reg[15:0], 1'b0};
            end
        end else if (cmd.div_store) begin
            tan_reg[cmd.comp] <= q_cap[15:0];
        end
    end

    // result fields
    assign target_vertex = corner_reg[cmd.out_k];
    assign degenerate    = sts.deg;
    assign tan_x         = sts.deg ? '0 : tan_reg[0];
    assign tan_y         = sts.deg ? '0 : tan_reg[1];
    assign tan_z         = sts.deg ? '0 : tan_reg[2];
endmodule
`default_nettype wire

@@ rtl/triangle_tangent_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_generator
// Per-triangle tangent from positions and UVs, normalized to Q1.15.
// ----------------------------------------------------------------------------
// Load item: written in the accept cycle, next item taken the following cycle.
// Triangle item: fetch, multiply, bit-serial normalize, square-sum,
// bit-serial square root and divide; a degenerate one goes from normalize to
// its results. Then three results, one at a time; no new item is taken before
// the last is out. Synchronous active-low reset clears the controller; the
// vertex store is not cleared and is undefined until written.
// ----------------------------------------------------------------------------
module triangle_tangent_generator #(
    parameter int VERTEX_COUNT = trg_pkg::TRG_VERTEX_COUNT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // s_tdata, low bit up: vertex_slot, pos_x, pos_y, pos_z, tex_u, tex_v,
    // corner_a, corner_b, corner_c
    input  wire logic [trg_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tuser,   // req_type
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // m_tdata, low bit up: target_vertex, tan_x, tan_y, tan_z, zero pad
    output logic [trg_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,   // degenerate
    output logic                               m_tlast,   // last_corner
    output logic                               m_tvalid,
    input  wire logic                          m_tready
);
    import trg_pkg::*;

    trg_cmd_t cmd;
    trg_sts_t sts;

    logic             in_take;
    logic             out_take;
    logic [IDX_W-1:0] target_vertex;
    logic [TAN_W-1:0] tan_x, tan_y, tan_z;

    // req_type 0 loads a vertex, 1 starts a triangle
    assign in_take  = s_tvalid && s_tready;
    assign out_take = m_tvalid && m_tready;

    trg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tri_start (in_take && s_tuser),
        .out_take  (out_take),
        .sts       (sts),
        .cmd       (cmd),
        .s_ready   (s_tready),
        .m_valid   (m_tvalid),
        .m_last    (m_tlast)
    );

    trg_dp #(
        .VERTEX_COUNT (VERTEX_COUNT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .load_en       (in_take && !s_tuser),
        .tri_start     (in_take && s_tuser),
        .in_data       (s_tdata),
        .sts           (sts),
        .target_vertex (target_vertex),
        .tan_x         (tan_x),
        .tan_y         (tan_y),
        .tan_z         (tan_z),
        .degenerate    (m_tuser)
    );

    assign m_tdata = {4'b0, tan_z, tan_y, tan_x, target_vertex};
endmodule
`default_nettype wire
